// ----- rtl/aatm_pkg.sv -----
// Shared types and constants for the tile mapper.
package aatm_pkg;
   localparam int CFG_IDX_BITS = 3;
   localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_TILE_WIDTH    = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_TILE_HEIGHT   = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_MAX_VALUE     = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] REG_ALPHABET_LAST = 3'd5;
   localparam logic [CFG_IDX_BITS-1:0] REG_GLYPHS_LOW    = 3'd6;
   localparam logic [CFG_IDX_BITS-1:0] REG_GLYPHS_HIGH   = 3'd7;
   localparam int CFG_DATA_BITS = 64;
   localparam int GLYPH_BITS = 8;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ACC  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;
endpackage

// ----- rtl/aatm_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module aatm_divider #(
   parameter int N_BITS = 32,
   parameter int D_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [N_BITS-1:0] numer,
   input  logic [D_BITS-1:0] denom,
   output logic              done,
   output logic [N_BITS-1:0] quot
);
   localparam int CNT_BITS = $clog2(N_BITS + 1);
   logic [N_BITS-1:0] q_ff, q_in;
   logic [D_BITS:0] r_ff, r_in;
   logic [D_BITS-1:0] d_ff, d_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [D_BITS:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[D_BITS-1:0], q_ff[N_BITS-1]};
      if (start) begin
         q_in = numer; r_in = '0; d_in = denom;
         cnt_in = CNT_BITS'(N_BITS); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[N_BITS-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[N_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ----- rtl/ascii_art_tile_mapper.sv -----
// Top level: tile accumulation over a band-sum memory and glyph selection.
// An item that closes a tile shows its glyph after two serial divisions, area then max_value.
// Each sample is taken in ST_IDLE (memory read), then added and written back in ST_ACC;
// no new sample is taken before that, and a finishing tile holds the input through ST_DIV
// and ST_OUT, longer only while an older result stalls.
// Reset clears position counters, state and the result valid flag and restores
// register defaults; the band-sum memory is not cleared and is written before read.
module ascii_art_tile_mapper #(
   parameter int MAX_WIDTH   = 4096,
   parameter int MAX_TILE    = 64,
   parameter int MAX_GLYPHS  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [15:0] req_sample,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_glyph,
   output logic rsp_end_of_line,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [aatm_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  logic [aatm_pkg::CFG_DATA_BITS-1:0] csr_data
);
   import aatm_pkg::*;

   localparam int POS_BITS  = $clog2(MAX_WIDTH);
   localparam int TIN_BITS  = $clog2(MAX_TILE);
   localparam int TSZ_BITS  = TIN_BITS + 1;
   localparam int AREA_BITS = 2 * TSZ_BITS;
   localparam int SUM_BITS  = SAMPLE_BITS + 2 * TIN_BITS;
   localparam int GI_BITS   = $clog2(MAX_GLYPHS);
   localparam int PROD_BITS = SUM_BITS + GI_BITS;
   localparam int DEN_BITS  = (AREA_BITS + 2 > 16) ? AREA_BITS + 2 : 16;

   // configuration registers
   logic [12:0] iw_ff, ih_ff;
   logic [6:0]  tw_ff, th_ff;
   logic [15:0] mv_ff;
   logic [3:0]  al_ff;
   logic [63:0] gl_ff, gh_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= 13'd640; ih_ff <= 13'd480; tw_ff <= 7'd8; th_ff <= 7'd16;
         mv_ff <= 16'd255; al_ff <= 4'd9; gl_ff <= '0; gh_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   iw_ff <= csr_data[12:0];
            REG_IMAGE_HEIGHT:  ih_ff <= csr_data[12:0];
            REG_TILE_WIDTH:    tw_ff <= csr_data[6:0];
            REG_TILE_HEIGHT:   th_ff <= csr_data[6:0];
            REG_MAX_VALUE:     mv_ff <= csr_data[15:0];
            REG_ALPHABET_LAST: al_ff <= csr_data[3:0];
            REG_GLYPHS_LOW:    gl_ff <= csr_data;
            REG_GLYPHS_HIGH:   gh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp sizes: zero counts as one, oversize saturates
   logic [14:0] iw_c, ih_c;
   logic [TSZ_BITS:0] tw_c, th_c;
   logic [GI_BITS-1:0] last_c;
   logic [15:0] mv_c;
   always_comb begin
      iw_c = (iw_ff == 0) ? 15'd1 : (15'(iw_ff) > 15'(MAX_WIDTH) ? 15'(MAX_WIDTH) : 15'(iw_ff));
      ih_c = (ih_ff == 0) ? 15'd1 : (15'(ih_ff) > 15'(MAX_WIDTH) ? 15'(MAX_WIDTH) : 15'(ih_ff));
      tw_c = (tw_ff == 0) ? (TSZ_BITS+1)'(1) :
             (9'(tw_ff) > 9'(MAX_TILE) ? (TSZ_BITS+1)'(MAX_TILE) : (TSZ_BITS+1)'(tw_ff));
      th_c = (th_ff == 0) ? (TSZ_BITS+1)'(1) :
             (9'(th_ff) > 9'(MAX_TILE) ? (TSZ_BITS+1)'(MAX_TILE) : (TSZ_BITS+1)'(th_ff));
      last_c = (5'(al_ff) > 5'(MAX_GLYPHS - 1)) ? GI_BITS'(MAX_GLYPHS - 1) : GI_BITS'(al_ff);
      mv_c = (mv_ff == 0) ? 16'd1 : mv_ff;
   end

   // position state
   logic [POS_BITS:0] col_ff, row_ff, tci_ff;
   logic [TSZ_BITS:0] wtc_ff, wtr_ff;
   logic [SUM_BITS-1:0] run_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;
   state_type state_ff;

   // band-sum memory, one read port and one write port
   logic [SUM_BITS-1:0] band_mem [MAX_WIDTH];
   logic [SUM_BITS-1:0] band_rd_ff;
   logic band_we;
   logic [SUM_BITS-1:0] total;
   logic [POS_BITS-1:0] slot;
   assign slot = tci_ff[POS_BITS-1:0];

   always_ff @(posedge clock) begin
      if (band_we) band_mem[slot] <= total;
      band_rd_ff <= band_mem[slot];
   end

   logic last_col, last_row, tl_col, tl_row, close_tile, emit;
   always_comb begin
      last_col = (16'(col_ff) + 16'd1) >= 16'(iw_c);
      last_row = (16'(row_ff) + 16'd1) >= 16'(ih_c);
      tl_col   = (wtc_ff + 1'b1) >= tw_c;
      tl_row   = (wtr_ff + 1'b1) >= th_c;
      close_tile = last_col || tl_col;
      emit = close_tile && (last_row || tl_row);
      total = run_ff + SUM_BITS'(smp_ff);
      if (close_tile && wtr_ff != 0) total = total + band_rd_ff;
      band_we = (state_ff == ST_ACC) && close_tile && !emit;
   end

   // divider shared by area and max_value divisions
   logic div_start, div_done, div_phase_ff;
   logic [PROD_BITS-1:0] div_n, div_q;
   logic [AREA_BITS+1:0] area;
   logic [DEN_BITS-1:0] div_den;
   logic eol_ff;
   assign area = (AREA_BITS+2)'(tw_c * th_c);
   logic [PROD_BITS-1:0] prod;
   assign prod = PROD_BITS'(div_q[SUM_BITS-1:0] * last_c);
   // the area division starts from ST_ACC, the max_value division from ST_DIV
   assign div_den = (state_ff == ST_DIV) ? DEN_BITS'(mv_c) : DEN_BITS'(area);

   aatm_divider #(.N_BITS(PROD_BITS), .D_BITS(DEN_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_n),
      .denom(div_den), .done(div_done), .quot(div_q)
   );

   logic [7:0] glyph_ff;
   logic eol_out_ff;
   logic rsp_valid_ff;
   logic [GI_BITS-1:0] idx;
   logic [127:0] glyph_bank;
   assign glyph_bank = {gh_ff, gl_ff};
   assign idx = (div_q > PROD_BITS'(last_c)) ? last_c : div_q[GI_BITS-1:0];

   always_comb begin
      div_start = 1'b0;
      div_n = '0;
      if (state_ff == ST_DIV && div_done && !div_phase_ff) begin
         div_start = 1'b1;
         div_n = prod;
      end else if (state_ff == ST_ACC && emit) begin
         div_start = 1'b1;
         div_n = PROD_BITS'(total);
      end
   end

   // a waiting result does not block the input; only a finished glyph waits in ST_OUT
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !req_stall) smp_ff <= req_sample[SAMPLE_BITS-1:0];
      if (reset) begin
         state_ff <= ST_IDLE; col_ff <= '0; row_ff <= '0; tci_ff <= '0;
         wtc_ff <= '0; wtr_ff <= '0; run_ff <= '0; rsp_valid_ff <= 1'b0;
         div_phase_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_valid && !req_stall) state_ff <= ST_ACC;
            ST_ACC: begin
               // advance the position and accumulate
               run_ff <= close_tile ? '0 : total;
               if (last_col) begin
                  col_ff <= '0; wtc_ff <= '0; tci_ff <= '0;
                  if (last_row) begin
                     row_ff <= '0; wtr_ff <= '0;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                     wtr_ff <= tl_row ? '0 : wtr_ff + 1'b1;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
                  if (tl_col) begin
                     wtc_ff <= '0; tci_ff <= tci_ff + 1'b1;
                  end else begin
                     wtc_ff <= wtc_ff + 1'b1;
                  end
               end
               eol_ff <= last_col;
               div_phase_ff <= 1'b0;
               state_ff <= emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: if (div_done) begin
               if (!div_phase_ff) begin
                  div_phase_ff <= 1'b1;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: if (!rsp_valid_ff) begin
               // load the result register once the older result has gone
               glyph_ff <= glyph_bank[{idx, 3'b000} +: 8];
               eol_out_ff <= eol_ff;
               rsp_valid_ff <= 1'b1; state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_glyph = glyph_ff;
   assign rsp_end_of_line = eol_out_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_nostart_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_start) else $error("divider started when idle");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
endmodule

// ----- tb/sv/ascii_art_tile_mapper_tb.sv -----
// Self-checking testbench for the ASCII-art tile mapper: directed table, then random frames.
module ascii_art_tile_mapper_tb;
   import aatm_pkg::*;

   localparam int SETTLE_CYCLES = 200;   // covers the two serial divisions after a tile closes
   localparam int WATCHDOG_LIMIT = 5000; // cycles without any transfer before giving up
   localparam int RANDOM_ITEMS = 1500;
   localparam int BAND_DEPTH = 4096;

   typedef struct packed {
      logic [7:0] glyph;
      logic       eol;
   } tile_glyph_type;

   typedef enum logic {ROW_CSR, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [CFG_IDX_BITS-1:0]  idx;
      logic [CFG_DATA_BITS-1:0] data;
      logic [15:0]              sample;
      bit                       typed;
      logic [7:0]               glyph;
      bit                       eol;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_glyph;
   logic rsp_end_of_line;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CFG_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_DATA_BITS-1:0] csr_data = '0;

   ascii_art_tile_mapper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_glyph(rsp_glyph), .rsp_end_of_line(rsp_end_of_line),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Shadow registers, masked to their widths as the block sees them
   int unsigned reg_iw, reg_ih, reg_tw, reg_th, reg_max, reg_alpha;
   logic [63:0] reg_glyph_lo, reg_glyph_hi;

   // Shadow of the scan position and of the band sums
   int unsigned pos_col, pos_row, in_tile_col, in_tile_row, tile_col;
   longint unsigned row_tile_sum;
   longint unsigned band_sum [BAND_DEPTH];

   tile_glyph_type pending_glyphs[$];
   int errors = 0;
   int idle_cycles = 0;
   int random_items = 0;
   int burst_left = 0;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic [7:0] glyph_for(longint unsigned total, int unsigned tw,
                                            int unsigned th);
      longint unsigned avg, idx, last, mv;
      avg  = total / (tw * th);
      last = 64'(reg_alpha);
      mv   = (reg_max == 0) ? 64'd1 : 64'(reg_max);
      idx  = (avg * last) / mv;
      if (idx > last) idx = last;
      if (idx < 8) return reg_glyph_lo[8*idx +: 8];
      return reg_glyph_hi[8*(idx-8) +: 8];
   endfunction

   task automatic shadow_write(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] d);
      case (idx)
         REG_IMAGE_WIDTH:   reg_iw = 32'(d[12:0]);
         REG_IMAGE_HEIGHT:  reg_ih = 32'(d[12:0]);
         REG_TILE_WIDTH:    reg_tw = 32'(d[6:0]);
         REG_TILE_HEIGHT:   reg_th = 32'(d[6:0]);
         REG_MAX_VALUE:     reg_max = 32'(d[15:0]);
         REG_ALPHABET_LAST: reg_alpha = 32'(d[3:0]);
         REG_GLYPHS_LOW:    reg_glyph_lo = d;
         REG_GLYPHS_HIGH:   reg_glyph_hi = d;
         default: ;
      endcase
   endtask

   // Advance the shadow by one pixel; report the glyph when a tile closes.
   task automatic predict_tile_glyph(input logic [15:0] s, output bit hit,
                                     output tile_glyph_type res);
      int unsigned iw, ih, tw, th;
      bit last_col, last_row, t_last_col, t_last_row;
      longint unsigned total;
      iw = clamp_dim(reg_iw, BAND_DEPTH);
      ih = clamp_dim(reg_ih, BAND_DEPTH);
      tw = clamp_dim(reg_tw, 64);
      th = clamp_dim(reg_th, 64);
      last_col   = pos_col + 1 >= iw;
      last_row   = pos_row + 1 >= ih;
      t_last_col = in_tile_col + 1 >= tw;
      t_last_row = in_tile_row + 1 >= th;
      hit = 1'b0;
      res = '0;
      row_tile_sum += 64'(s);
      if (last_col || t_last_col) begin
         total = row_tile_sum;
         if (in_tile_row != 0) total += band_sum[tile_col % BAND_DEPTH];
         row_tile_sum = 0;
         if (last_row || t_last_row) begin
            hit = 1'b1;
            res.glyph = glyph_for(total, tw, th);
            res.eol = last_col;
         end else begin
            band_sum[tile_col % BAND_DEPTH] = total;
         end
      end
      if (last_col) begin
         pos_col = 0; in_tile_col = 0; tile_col = 0;
         if (last_row) begin
            pos_row = 0; in_tile_row = 0;
         end else begin
            pos_row++;
            in_tile_row = t_last_row ? 0 : in_tile_row + 1;
         end
      end else begin
         pos_col++;
         if (t_last_col) begin
            in_tile_col = 0;
            tile_col++;
         end else begin
            in_tile_col++;
         end
      end
   endtask

   // Write one register once the block has drained; a pixel that closes no
   // tile may still be in flight, so let the settle time pass as well.
   task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] d);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_write(idx, d);
   endtask

   // Drive one pixel in bursts; queue its expected glyph on transfer.
   task automatic send_pixel(input logic [15:0] s, input bit typed,
                             input logic [7:0] g, input bit e);
      bit hit;
      tile_glyph_type res;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      predict_tile_glyph(s, hit, res);
      if (typed) pending_glyphs.push_back('{glyph: g, eol: e});
      else if (hit) pending_glyphs.push_back(res);
   endtask

   // Receiver: switch between no stall, random stall and long stall runs.
   int stall_mode = 0, mode_left = 0, run_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            if (run_left == 0 && $urandom_range(0, 9) == 0) run_left = $urandom_range(1, 20);
            rsp_stall <= (run_left != 0);
            if (run_left != 0) run_left--;
         end
      endcase
   end

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      tile_glyph_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_glyphs.size() == 0) begin
            errors++;
            $display("%0t: unexpected result glyph %h eol %b", $time, rsp_glyph,
                     rsp_end_of_line);
         end else begin
            want = pending_glyphs.pop_front();
            if (rsp_glyph !== want.glyph) begin
               errors++;
               $display("%0t: glyph expected %h actual %h", $time, want.glyph, rsp_glyph);
            end
            if (rsp_end_of_line !== want.eol) begin
               errors++;
               $display("%0t: end_of_line expected %b actual %b", $time, want.eol,
                        rsp_end_of_line);
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer on any channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ascii_art_tile_mapper_tb NOT OK");
         $finish;
      end
   end

   // Directed rows: tiny images with 1x1 tiles give glyphs readable at a glance,
   // then zero and oversize registers, a width cut mid-row on a one-row image,
   // and a one-glyph alphabet.
   stim_row_type directed [] = '{
      '{ROW_CSR, REG_IMAGE_WIDTH,   64'd2, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_IMAGE_HEIGHT,  64'd2, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_TILE_WIDTH,    64'd1, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_TILE_HEIGHT,   64'd1, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_MAX_VALUE,     64'd65535, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_ALPHABET_LAST, 64'd15, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_GLYPHS_LOW,    64'h0706050403020100, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_GLYPHS_HIGH,   64'h0F0E0D0C0B0A0908, 16'h0, 0, 8'h00, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'h0000, 1, 8'h00, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'hFFFF, 1, 8'h0F, 1},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'h8000, 1, 8'h07, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'h0001, 1, 8'h00, 1},
      // zero tile width, oversize tile height, zero max_value
      '{ROW_CSR, REG_TILE_WIDTH,    64'd0, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_TILE_HEIGHT,   64'd127, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_IMAGE_HEIGHT,  64'd1, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_MAX_VALUE,     64'd0, 16'h0, 0, 8'h00, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'hFFFF, 1, 8'h0F, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'h0000, 1, 8'h00, 1},
      // oversize width and tile, then the row cut short
      '{ROW_CSR, REG_IMAGE_WIDTH,   64'd8191, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_TILE_WIDTH,    64'd127, 16'h0, 0, 8'h00, 0},
      '{ROW_CSR, REG_MAX_VALUE,     64'd65535, 16'h0, 0, 8'h00, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'hFFFF, 0, 8'h00, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'h1234, 0, 8'h00, 0},
      '{ROW_CSR, REG_IMAGE_WIDTH,   64'd0, 16'h0, 0, 8'h00, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'h5555, 0, 8'h00, 0},
      '{ROW_CSR, REG_ALPHABET_LAST, 64'd0, 16'h0, 0, 8'h00, 0},
      '{ROW_PIX, REG_IMAGE_WIDTH,   64'd0, 16'hFFFF, 1, 8'h00, 1}
   };

   function automatic logic [15:0] pick_sample();
      int unsigned mv;
      mv = (reg_max == 0) ? 1 : reg_max;
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return mv[15:0];
         default: return 16'($urandom_range(0, mv));
      endcase
   endfunction

   initial begin
      int unsigned iw, ih, n_pix, phase;
      logic [CFG_DATA_BITS-1:0] d;
      // Shadow starts from the reset defaults
      reg_iw = 640; reg_ih = 480; reg_tw = 8; reg_th = 16;
      reg_max = 255; reg_alpha = 9; reg_glyph_lo = '0; reg_glyph_hi = '0;
      pos_col = 0; pos_row = 0; in_tile_col = 0; in_tile_row = 0; tile_col = 0;
      row_tile_sum = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) write_reg(directed[i].idx, directed[i].data);
         else send_pixel(directed[i].sample, directed[i].typed, directed[i].glyph,
                         directed[i].eol);
      end

      // Random phases: every register rewritten, whole frames per setting so
      // no band sum is read before this frame wrote it.
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         d = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'($urandom_range(0, 40))
                                         : CFG_DATA_BITS'($urandom_range(1, 10));
         write_reg(REG_IMAGE_WIDTH, d);
         write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'($urandom_range(0, 6)));
         d = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom_range(64, 127))
                                         : CFG_DATA_BITS'($urandom_range(0, 10));
         write_reg(REG_TILE_WIDTH, d);
         d = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom_range(64, 127))
                                         : CFG_DATA_BITS'($urandom_range(0, 6));
         write_reg(REG_TILE_HEIGHT, d);
         case ($urandom_range(0, 3))
            0: d = 64'd1;
            1: d = 64'd65535;
            2: d = 64'd255;
            default: d = CFG_DATA_BITS'($urandom_range(0, 65535));
         endcase
         write_reg(REG_MAX_VALUE, d);
         write_reg(REG_ALPHABET_LAST, CFG_DATA_BITS'($urandom_range(0, 15)));
         write_reg(REG_GLYPHS_LOW, {$urandom, $urandom});
         write_reg(REG_GLYPHS_HIGH, {$urandom, $urandom});
         iw = clamp_dim(reg_iw, BAND_DEPTH);
         ih = clamp_dim(reg_ih, BAND_DEPTH);
         n_pix = iw * ih * $urandom_range(1, 3);
         for (int unsigned k = 0; k < n_pix; k++) begin
            // Hold off until drained mid-frame, then swap the glyph set
            if (phase % 4 == 2 && k == n_pix / 2)
               write_reg(REG_GLYPHS_LOW, {$urandom, $urandom});
            send_pixel(pick_sample(), 0, 8'h00, 0);
            random_items++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("ascii_art_tile_mapper_tb OK");
      end else begin
         $display("ascii_art_tile_mapper_tb NOT OK");
      end
      $finish;
   end
endmodule

// ----- ascii_art_tile_mapper.f -----
rtl/aatm_pkg.sv
rtl/aatm_divider.sv
rtl/ascii_art_tile_mapper.sv
tb/sv/ascii_art_tile_mapper_tb.sv
